// ===== rtl/tbhd_pkg.sv =====
// types and constants for the track to bar hit distance block
package tbhd_pkg;

	localparam int COORD_BITS = 20;
	localparam int DIST_BITS  = 21;
	localparam int ADDR_BITS  = 4;

	localparam logic [1:0] REG_X_ZERO_LIMIT  = 2'd0;
	localparam logic [1:0] REG_Y_WINDOW_LOW  = 2'd1;
	localparam logic [1:0] REG_Y_WINDOW_HIGH = 2'd2;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_DEGEN   = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] start_z;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic signed [COORD_BITS-1:0] end_z;
		logic signed [COORD_BITS-1:0] hit_x;
		logic signed [COORD_BITS-1:0] hit_y;
		logic signed [COORD_BITS-1:0] hit_z;
	} request_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic [1:0]           status;
		logic                 bar_along_y;
	} result_t;

	typedef struct packed {
		logic unknown;
		logic degen;
		logic along_y;
	} flags_t;

endpackage

// ===== rtl/track_to_bar_hit_distance.sv =====
// track to bar hit distance, pipelined with an unrolled square root search
//
// channel   signals                              transfer
// request   start, busy, request                 start high and busy low
// result    done, result                         done high, one cycle, no backpressure
// config    psel penable pwrite paddr pwdata     apb write, pready always high
//
// one request per cycle; each request passes the front stages, the root search and the output register
// 6 front stages, one stage per bit of the 21-bit root search, then the output register
// busy is always low; results cannot be held off
// reset clears the valid bits and loads the config registers with 0, 800 and 880
module track_to_bar_hit_distance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  tbhd_pkg::request_t                 request,
	output logic                               done,
	output tbhd_pkg::result_t                  result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tbhd_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int CB  = tbhd_pkg::COORD_BITS;
	localparam int QB  = tbhd_pkg::DIST_BITS;
	localparam int DW  = CB + 1;
	localparam int PW  = 2 * DW;
	localparam int NL  = PW / 2;
	localparam int NH  = PW - NL;
	localparam int SW  = 2 * PW;
	localparam int QDW = PW + QB;
	localparam int TW  = SW + 2;

	logic signed [CB-1:0] x_zero_limit_q, y_window_low_q, y_window_high_q;
	logic                 wr_en;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_zero_limit_q  <= CB'(0);
			y_window_low_q  <= CB'(800);
			y_window_high_q <= CB'(880);
		end else if (wr_en) begin
			case (paddr[3:2])
				tbhd_pkg::REG_X_ZERO_LIMIT:  x_zero_limit_q  <= pwdata[CB-1:0];
				tbhd_pkg::REG_Y_WINDOW_LOW:  y_window_low_q  <= pwdata[CB-1:0];
				tbhd_pkg::REG_Y_WINDOW_HIGH: y_window_high_q <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tbhd_pkg::REG_X_ZERO_LIMIT:  prdata = 32'(x_zero_limit_q);
			tbhd_pkg::REG_Y_WINDOW_LOW:  prdata = 32'(y_window_low_q);
			tbhd_pkg::REG_Y_WINDOW_HIGH: prdata = 32'(y_window_high_q);
			default:                     prdata = 32'd0;
		endcase
	end

	// stage 1: capture request
	tbhd_pkg::request_t req_s1;
	logic               v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) req_s1 <= request;
	end

	// stage 2: differences and axis selection
	logic signed [DW-1:0] ax, ay, az, cx, cy, cz;
	logic                 sel_x, sel_y;
	logic signed [DW-1:0] m1a_s2, m1b_s2, m2a_s2, m2b_s2, da_s2, db_s2;
	tbhd_pkg::flags_t     fl_s2;
	logic                 v_s2;

	always_comb begin
		ax    = DW'(req_s1.end_x) - DW'(req_s1.start_x);
		ay    = DW'(req_s1.end_y) - DW'(req_s1.start_y);
		az    = DW'(req_s1.end_z) - DW'(req_s1.start_z);
		cx    = DW'(req_s1.hit_x) - DW'(req_s1.start_x);
		cy    = DW'(req_s1.hit_y) - DW'(req_s1.start_y);
		cz    = DW'(req_s1.hit_z) - DW'(req_s1.start_z);
		sel_x = req_s1.hit_x <= x_zero_limit_q;
		sel_y = (req_s1.hit_y >= y_window_low_q) && (req_s1.hit_y <= y_window_high_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (sel_x) begin
			m1a_s2 <= cy; m1b_s2 <= az; m2a_s2 <= cz; m2b_s2 <= ay;
			da_s2  <= ay; db_s2  <= az;
		end else begin
			m1a_s2 <= cz; m1b_s2 <= ax; m2a_s2 <= cx; m2b_s2 <= az;
			da_s2  <= az; db_s2  <= ax;
		end
		fl_s2.unknown <= ~sel_x & ~sel_y;
		fl_s2.along_y <= ~sel_x & sel_y;
		fl_s2.degen   <= 1'b0;
	end

	// stage 3: products
	logic signed [PW-1:0] p1_s3, p2_s3, sq1_s3, sq2_s3;
	tbhd_pkg::flags_t     fl_s3;
	logic                 v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		p1_s3  <= m1a_s2 * m1b_s2;
		p2_s3  <= m2a_s2 * m2b_s2;
		sq1_s3 <= da_s2 * da_s2;
		sq2_s3 <= db_s2 * db_s2;
		fl_s3  <= fl_s2;
	end

	// stage 4: numerator magnitude and denominator
	logic signed [PW:0] ndiff;
	logic [PW-1:0]      n_s4, d_s4;
	tbhd_pkg::flags_t   fl_s4;
	logic               v_s4;

	assign ndiff = (PW+1)'(p1_s3) - (PW+1)'(p2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		n_s4  <= ndiff[PW] ? PW'(-ndiff) : PW'(ndiff);
		d_s4  <= PW'($unsigned(sq1_s3)) + PW'($unsigned(sq2_s3));
		fl_s4 <= fl_s3;
	end

	// stage 5: partial products of the numerator square
	logic [2*NH-1:0]    hh_s5;
	logic [NH+NL-1:0]   hl_s5;
	logic [2*NL-1:0]    ll_s5;
	logic [PW-1:0]      d_s5;
	tbhd_pkg::flags_t   fl_s5;
	logic               v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		hh_s5 <= n_s4[PW-1:NL] * n_s4[PW-1:NL];
		hl_s5 <= n_s4[PW-1:NL] * n_s4[NL-1:0];
		ll_s5 <= n_s4[NL-1:0] * n_s4[NL-1:0];
		d_s5  <= d_s4;
		fl_s5.unknown <= fl_s4.unknown;
		fl_s5.along_y <= fl_s4.along_y;
		fl_s5.degen   <= (d_s4 == '0);
	end

	// stage 6: numerator square
	logic [SW-1:0]    nsq_s6;
	logic [PW-1:0]    d_s6;
	tbhd_pkg::flags_t fl_s6;
	logic             v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		nsq_s6 <= (SW'(hh_s5) << (2 * NL)) + (SW'(hl_s5) << (NL + 1)) + SW'(ll_s5);
		d_s6   <= d_s5;
		fl_s6  <= fl_s5;
	end

	// root search, one bit per stage: remainder, q*D and q
	logic [SW-1:0]    rem_s [QB+1];
	logic [QDW-1:0]   qd_s  [QB+1];
	logic [QB-1:0]    q_s   [QB+1];
	logic [PW-1:0]    d_s   [QB+1];
	tbhd_pkg::flags_t fl_s  [QB+1];
	logic             v_s   [QB+1];

	assign rem_s[0] = nsq_s6;
	assign qd_s[0]  = '0;
	assign q_s[0]   = '0;
	assign d_s[0]   = d_s6;
	assign fl_s[0]  = fl_s6;
	assign v_s[0]   = v_s6;

	for (genvar j = 0; j < QB; j++) begin : g_root
		localparam int K = QB - 1 - j;
		logic [TW-1:0] trial;
		logic          take;

		assign trial = (TW'(qd_s[j]) << (K + 1)) + (TW'(d_s[j]) << (2 * K));
		assign take  = trial <= TW'(rem_s[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j+1] <= 1'b0;
			else         v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= take ? SW'(TW'(rem_s[j]) - trial) : rem_s[j];
			qd_s[j+1]  <= take ? qd_s[j] + (QDW'(d_s[j]) << K) : qd_s[j];
			q_s[j+1]   <= take ? (q_s[j] | (QB'(1) << K)) : q_s[j];
			d_s[j+1]   <= d_s[j];
			fl_s[j+1]  <= fl_s[j];
		end
	end

	// output register
	tbhd_pkg::result_t res_q;
	logic              done_q;
	tbhd_pkg::flags_t  fo;

	assign fo = fl_s[QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= v_s[QB];
	end

	always_ff @(posedge clk) begin
		if (fo.unknown) begin
			res_q.distance    <= '0;
			res_q.status      <= tbhd_pkg::ST_UNKNOWN;
			res_q.bar_along_y <= 1'b0;
		end else if (fo.degen) begin
			res_q.distance    <= '0;
			res_q.status      <= tbhd_pkg::ST_DEGEN;
			res_q.bar_along_y <= fo.along_y;
		end else begin
			res_q.distance    <= q_s[QB];
			res_q.status      <= tbhd_pkg::ST_OK;
			res_q.bar_along_y <= fo.along_y;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/tbhd_checker.sv =====
// port checker for the track to bar hit distance block
module tbhd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               busy,
	input logic               done,
	input tbhd_pkg::result_t  result,
	input logic               pready
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == tbhd_pkg::ST_OK || result.status == tbhd_pkg::ST_UNKNOWN
			|| result.status == tbhd_pkg::ST_DEGEN))
		else $error("bad status");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != tbhd_pkg::ST_OK |-> result.distance == '0)
		else $error("distance not zero on failure");

	a_unknown_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == tbhd_pkg::ST_UNKNOWN |-> !result.bar_along_y)
		else $error("axis set on unknown");

endmodule

bind track_to_bar_hit_distance tbhd_checker u_tbhd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.done   (done),
	.result (result),
	.pready (pready)
);

// ===== tb/sv/tb_track_to_bar_hit_distance.sv =====
// testbench for track_to_bar_hit_distance: random and directed requests, predicted results
module tb_track_to_bar_hit_distance;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LATENCY     = 28;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  CMIN        = -(1 << (tbhd_pkg::COORD_BITS - 1));
	localparam int  CMAX        = (1 << (tbhd_pkg::COORD_BITS - 1)) - 1;
	localparam logic signed [tbhd_pkg::COORD_BITS-1:0] MIN_COORD = tbhd_pkg::COORD_BITS'(CMIN);
	localparam logic signed [tbhd_pkg::COORD_BITS-1:0] MAX_COORD = tbhd_pkg::COORD_BITS'(CMAX);

	typedef enum int {HIT_ALONG_X, HIT_ALONG_Y, HIT_UNKNOWN, HIT_ANY} hit_kind_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	tbhd_pkg::request_t             request = '0;
	logic                           done;
	tbhd_pkg::result_t              result;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [tbhd_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;

	int                  lim_x = 0;
	int                  win_lo = 800;
	int                  win_hi = 880;
	tbhd_pkg::request_t  pending_requests[$];
	tbhd_pkg::result_t   expected_results[$];
	int                  gap = 0;
	bit                  no_idle = 1'b0;
	int                  errors = 0;
	longint              cycles = 0;

	track_to_bar_hit_distance u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	function automatic tbhd_pkg::result_t bar_distance(tbhd_pkg::request_t r);
		tbhd_pkg::result_t res;
		longint      sx, sy, sz, ax, ay, az, cx, cy, cz, num, den, t, q;
		bit [127:0]  n2, lhs;
		sx = r.start_x; sy = r.start_y; sz = r.start_z;
		ax = longint'(r.end_x) - sx; ay = longint'(r.end_y) - sy; az = longint'(r.end_z) - sz;
		cx = longint'(r.hit_x) - sx; cy = longint'(r.hit_y) - sy; cz = longint'(r.hit_z) - sz;
		res = '0;
		if (int'(r.hit_x) <= lim_x) begin
			num = cy * az - cz * ay;
			den = ay * ay + az * az;
		end else if (int'(r.hit_y) >= win_lo && int'(r.hit_y) <= win_hi) begin
			res.bar_along_y = 1'b1;
			num = cz * ax - cx * az;
			den = az * az + ax * ax;
		end else begin
			res.status = tbhd_pkg::ST_UNKNOWN;
			return res;
		end
		if (den == 0) begin
			res.status = tbhd_pkg::ST_DEGEN;
			return res;
		end
		if (num < 0) num = -num;
		n2 = 128'(num) * 128'(num);
		q = 0;
		for (int b = tbhd_pkg::DIST_BITS - 1; b >= 0; b--) begin
			t = q | (64'd1 << b);
			lhs = 128'(t) * 128'(t) * 128'(den);
			if (lhs <= n2) q = t;
		end
		res.distance = q[tbhd_pkg::DIST_BITS-1:0];
		res.status = tbhd_pkg::ST_OK;
		return res;
	endfunction

	function automatic logic signed [tbhd_pkg::COORD_BITS-1:0] coord_in(int lo, int hi);
		return tbhd_pkg::COORD_BITS'(lo + int'($urandom_range(hi - lo)));
	endfunction

	function automatic logic signed [tbhd_pkg::COORD_BITS-1:0] any_coord();
		case ($urandom_range(3))
			0: return tbhd_pkg::COORD_BITS'($urandom);
			1: return coord_in(-64, 64);
			2: return $urandom_range(1) ? MIN_COORD : MAX_COORD;
			default: return coord_in(-20000, 20000);
		endcase
	endfunction

	function automatic tbhd_pkg::request_t random_request(hit_kind_t kind);
		tbhd_pkg::request_t r;
		r.start_x = any_coord(); r.start_y = any_coord(); r.start_z = any_coord();
		r.end_x = any_coord(); r.end_y = any_coord(); r.end_z = any_coord();
		r.hit_x = any_coord(); r.hit_y = any_coord(); r.hit_z = any_coord();
		case (kind)
			HIT_ALONG_X: r.hit_x = coord_in(CMIN, lim_x);
			HIT_ALONG_Y: begin
				if (lim_x < CMAX) r.hit_x = coord_in(lim_x + 1, CMAX);
				if (win_lo <= win_hi) r.hit_y = coord_in(win_lo, win_hi);
			end
			HIT_UNKNOWN: if (lim_x < CMAX) r.hit_x = coord_in(lim_x + 1, CMAX);
			default: ;
		endcase
		// parallel or zero-length track
		if ($urandom_range(9) == 0) begin
			r.end_y = r.start_y; r.end_z = r.start_z;
			if ($urandom_range(1)) r.end_x = r.start_x;
		end else if ($urandom_range(9) == 0) begin
			r.end_z = r.start_z; r.end_x = r.start_x;
		end
		return r;
	endfunction

	// request driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** track_to_bar_hit_distance: FAILED **");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(bar_distance(request));
			if (start && busy) begin
			end else if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				request <= pending_requests.pop_front();
				start <= 1'b1;
				if ($urandom_range(39) == 0) no_idle = ~no_idle;
				gap <= no_idle ? 0 : $urandom_range(17);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		tbhd_pkg::result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.distance !== want.distance) begin
					$display("%0t: distance expected %0d actual %0d", $time, want.distance,
						result.distance);
					errors++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						result.status);
					errors++;
				end
				if (result.bar_along_y !== want.bar_along_y) begin
					$display("%0t: bar_along_y expected %0b actual %0b", $time,
						want.bar_along_y, result.bar_along_y);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, int value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			tbhd_pkg::REG_X_ZERO_LIMIT: lim_x = value;
			tbhd_pkg::REG_Y_WINDOW_LOW: win_lo = value;
			default: win_hi = value;
		endcase
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic configure(int lx, int lo, int hi);
		write_reg(tbhd_pkg::REG_X_ZERO_LIMIT, lx);
		write_reg(tbhd_pkg::REG_Y_WINDOW_LOW, lo);
		write_reg(tbhd_pkg::REG_Y_WINDOW_HIGH, hi);
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			pending_requests.push_back(random_request(hit_kind_t'($urandom_range(3))));
	endtask

	initial begin
		tbhd_pkg::request_t r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		configure(0, 800, 880);
		// directed: extremes, both axes, unknown, degenerate, saturation
		r = '0; r.end_z = 20'sd16; r.hit_y = 20'sd32;
		pending_requests.push_back(r);
		r = '0; pending_requests.push_back(r);
		r = '0; r.end_x = 20'sd100; pending_requests.push_back(r);
		r = '0; r.end_y = 20'sd5; r.end_z = 20'sd5; r.hit_x = 20'sd1; r.hit_y = 20'sd800;
		pending_requests.push_back(r);
		r.hit_y = 20'sd880; pending_requests.push_back(r);
		r.hit_y = 20'sd881; pending_requests.push_back(r);
		r.hit_y = 20'sd799; pending_requests.push_back(r);
		r = '0; r.end_y = 20'sd9; r.hit_x = 20'sd3; r.hit_y = 20'sd840;
		pending_requests.push_back(r);
		r = '1; pending_requests.push_back(r);
		r.start_x = MIN_COORD; r.start_y = MIN_COORD; r.start_z = MIN_COORD;
		r.end_x = MAX_COORD; r.end_y = MAX_COORD; r.end_z = MIN_COORD;
		r.hit_x = MIN_COORD; r.hit_y = MAX_COORD; r.hit_z = MAX_COORD;
		pending_requests.push_back(r);
		r.start_z = MAX_COORD; r.end_z = MIN_COORD; r.hit_z = MIN_COORD; r.end_y = MIN_COORD;
		r.hit_y = MAX_COORD; pending_requests.push_back(r);
		r.hit_x = MAX_COORD; r.hit_y = 20'sd850; r.end_x = MIN_COORD; r.start_x = MAX_COORD;
		pending_requests.push_back(r);
		r = '0; r.start_x = MAX_COORD; r.end_x = MIN_COORD; r.end_y = 20'sd1;
		r.hit_z = MAX_COORD; r.hit_y = MAX_COORD; pending_requests.push_back(r);
		r = '0; r.hit_x = 20'sd0; r.end_y = 20'sd1; r.end_z = 20'sd1; r.hit_y = 20'sd1;
		pending_requests.push_back(r);
		r.hit_x = 20'sd1; r.hit_y = 20'sd1; pending_requests.push_back(r);
		random_phase(110);
		drain();
		configure(CMIN, CMIN, CMAX);
		random_phase(130);
		drain();
		configure(CMAX, 0, 0);
		random_phase(100);
		drain();
		configure(-1000, 900, 100);
		random_phase(120);
		drain();
		configure(CMAX - 1, CMAX, CMAX);
		random_phase(80);
		drain();
		configure(int'($urandom_range(4000)) - 2000, -300, 300);
		random_phase(140);
		drain();
		if (errors == 0 && expected_results.size() == 0)
			$display("** track_to_bar_hit_distance: PASSED **");
		else
			$display("** track_to_bar_hit_distance: FAILED **");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/tbhd_pkg.sv
rtl/track_to_bar_hit_distance.sv
rtl/tbhd_checker.sv
tb/sv/tb_track_to_bar_hit_distance.sv
